/* rtl/assert_macros.svh */
// Assertion macros shared by the tag tracker RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/chmtt_pkg.sv */
// Shared types and constants of the cache tag tracker.
// Used by the front, queue, back and top level; depends on nothing.
package chmtt_pkg;

    localparam int ADDR_W        = 32;
    localparam int LINE_W        = 30;
    localparam int MAX_SET_COUNT = 1024;
    localparam int SET_W         = $clog2(MAX_SET_COUNT);
    localparam int WAY_COUNT     = 2;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LB_W      = 3;
    localparam int SL_W      = 4;

    localparam logic [LB_W-1:0] LB_MIN = 3'd2;
    localparam logic [LB_W-1:0] LB_MAX = 3'd4;
    localparam logic [SL_W-1:0] SL_MIN = 4'd7;
    localparam logic [SL_W-1:0] SL_MAX = 4'd10;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Operation codes of an input item.
    localparam logic OP_READ       = 1'b0;
    localparam logic OP_INVALIDATE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_BYTES_LOG2 = 3'd0,
        CFG_TWO_WAY_MODE    = 3'd1,
        CFG_SETS_LOG2       = 3'd2,
        CFG_REGION_BASE     = 3'd3,
        CFG_REGION_UPPER    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HIT_MISS = 2'd0,
        HIT_WAY1 = 2'd1,
        HIT_WAY2 = 2'd2
    } t_hit;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOKUP,
        BK_SWEEP
    } t_back_state;

    // A classified item as it waits in the queue.
    typedef struct packed {
        logic              invalidate;
        logic              in_region;
        logic              two;
        logic [LINE_W-1:0] line;
        logic [SET_W-1:0]  set_idx;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/chmtt_front.sv */
// Front end: configuration registers and classification of accepted items.
// Depends on chmtt_pkg.
module chmtt_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [chmtt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [chmtt_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic                                 i_operation,
    input  logic [chmtt_pkg::ADDR_W-1:0]         i_read_address,
    output logic                                 o_push,
    output chmtt_pkg::t_qentry                   o_entry
);
    import chmtt_pkg::*;

    logic [LB_W-1:0]   r_line_bytes_log2;
    logic              r_two_way_mode;
    logic [SL_W-1:0]   r_sets_log2;
    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_region_upper;

    logic [LB_W-1:0]   lb_c;
    logic [SL_W-1:0]   sl_c;
    logic [4:0]        span_sh;
    logic [ADDR_W-1:0] span_mask;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    logic [SET_W-1:0]  set_mask;
    logic [LINE_W-1:0] line;

    // Configuration registers, written by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes_log2 <= LB_MIN;
            r_two_way_mode    <= 1'b0;
            r_sets_log2       <= SL_MIN;
            r_region_base     <= '0;
            r_region_upper    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_BYTES_LOG2: r_line_bytes_log2 <= i_cfg_data[LB_W-1:0];
                CFG_TWO_WAY_MODE:    r_two_way_mode    <= i_cfg_data[0];
                CFG_SETS_LOG2:       r_sets_log2       <= i_cfg_data[SL_W-1:0];
                CFG_REGION_BASE:     r_region_base     <= i_cfg_data[ADDR_W-1:0];
                CFG_REGION_UPPER:    r_region_upper    <= i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Saturate the size registers to their legal ranges.
    always_comb begin
        if (r_line_bytes_log2 < LB_MIN) begin
            lb_c = LB_MIN;
        end else if (r_line_bytes_log2 > LB_MAX) begin
            lb_c = LB_MAX;
        end else begin
            lb_c = r_line_bytes_log2;
        end
        if (r_sets_log2 < SL_MIN) begin
            sl_c = SL_MIN;
        end else if (r_sets_log2 > SL_MAX) begin
            sl_c = SL_MAX;
        end else begin
            sl_c = r_sets_log2;
        end
    end

    // Region bounds are aligned down to the set span; the upper one wraps.
    assign span_sh   = {2'b00, lb_c} + {1'b0, sl_c};
    assign span_mask = {ADDR_W{1'b1}} << span_sh;
    assign base      = r_region_base & span_mask;
    assign limit     = (r_region_upper + ADDR_W'(1)) & span_mask;

    // Line address and set index; set index bits beyond the configured set count are masked off.
    assign line     = LINE_W'(i_read_address >> lb_c);
    assign set_mask = ~({SET_W{1'b1}} << sl_c);

    // Classify the item as it is accepted.
    assign o_push             = i_start && !i_busy;
    assign o_entry.invalidate = (i_operation == OP_INVALIDATE);
    assign o_entry.in_region  = (i_read_address >= base) && (i_read_address < limit);
    assign o_entry.two        = (WAY_COUNT >= 2) && r_two_way_mode;
    assign o_entry.line       = line;
    assign o_entry.set_idx    = line[SET_W-1:0] & set_mask;

endmodule

/* rtl/chmtt_queue.sv */
// Short FIFO of classified items between the front and the back.
// Depends on chmtt_pkg and assert_macros.svh.
module chmtt_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  chmtt_pkg::t_qentry   i_entry,
    input  logic                 i_pop,
    output chmtt_pkg::t_qentry   o_head,
    output chmtt_pkg::t_q_status o_status
);
    import chmtt_pkg::*;
    `include "assert_macros.svh"

    t_qentry            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    // Pointer and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    // The top level must hold items off when the queue is full.
    `CHK_SAME(a_no_push_full, i_push, !o_status.full || i_pop, "push into a full queue")
    `CHK_SAME(a_no_pop_empty, i_pop, !o_status.empty, "pop from an empty queue")

endmodule

/* rtl/chmtt_back.sv */
// Back end: tag, valid and round-robin stores, lookup, fill and sweeps.
// Depends on chmtt_pkg and assert_macros.svh.
module chmtt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chmtt_pkg::t_qentry   i_head,
    input  chmtt_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    output logic                 o_clearing,
    output logic                 o_res_valid,
    output chmtt_pkg::t_hit      o_res_hit
);
    import chmtt_pkg::*;
    `include "assert_macros.svh"

    t_back_state       r_state, n_state;
    logic [SET_W-1:0]  r_cnt, n_cnt;
    t_qentry           r_cur, n_cur;
    logic              r_out_valid, n_out_valid;
    t_hit              r_out_hit, n_out_hit;

    // Stores: one row per set.
    logic [LINE_W-1:0] r_tag0_mem [MAX_SET_COUNT];
    logic [LINE_W-1:0] r_tag1_mem [MAX_SET_COUNT];
    logic [1:0]        r_meta_mem [MAX_SET_COUNT];
    logic              r_rr_mem   [MAX_SET_COUNT];

    logic [LINE_W-1:0] r_tag0_q;
    logic [LINE_W-1:0] r_tag1_q;
    logic [1:0]        r_meta_q;
    logic              r_rr_q;

    logic              rd_en;
    logic              tag0_we;
    logic              tag1_we;
    logic              meta_we;
    logic [SET_W-1:0]  meta_addr;
    logic [1:0]        meta_wdata;
    logic              rr_we;
    logic [SET_W-1:0]  rr_addr;
    logic              rr_wdata;
    logic              hit0;
    logic              hit1;
    logic              last_cnt;

    assign hit0     = r_meta_q[0] && (r_tag0_q == r_cur.line);
    assign hit1     = r_cur.two && r_meta_q[1] && (r_tag1_q == r_cur.line);
    assign last_cnt = (r_cnt == SET_W'(MAX_SET_COUNT - 1));

    // Sequencer: clear pass, lookup and fill, invalidate sweep.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_out_valid = 1'b0;
        n_out_hit   = r_out_hit;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        tag0_we     = 1'b0;
        tag1_we     = 1'b0;
        meta_we     = 1'b0;
        meta_addr   = r_cnt;
        meta_wdata  = 2'b00;
        rr_we       = 1'b0;
        rr_addr     = r_cnt;
        rr_wdata    = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                meta_we = 1'b1;
                rr_we   = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (last_cnt) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    n_cur = i_head;
                    if (i_head.invalidate) begin
                        n_state = BK_SWEEP;
                        n_cnt   = '0;
                    end else if (!i_head.in_region) begin
                        n_out_valid = 1'b1;
                        n_out_hit   = HIT_MISS;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = BK_LOOKUP;
                    end
                end
            end
            BK_LOOKUP: begin
                n_out_valid = 1'b1;
                n_state     = BK_IDLE;
                if (hit0) begin
                    n_out_hit = HIT_WAY1;
                end else if (hit1) begin
                    n_out_hit = HIT_WAY2;
                end else begin
                    // Miss: fill the way picked by the set's round-robin bit in two-way mode, else the first way.
                    n_out_hit = HIT_MISS;
                    meta_we   = 1'b1;
                    meta_addr = r_cur.set_idx;
                    if (r_cur.two && r_rr_q) begin
                        tag1_we    = 1'b1;
                        meta_wdata = r_meta_q | 2'b10;
                    end else begin
                        tag0_we    = 1'b1;
                        meta_wdata = r_meta_q | 2'b01;
                    end
                    if (r_cur.two) begin
                        rr_we    = 1'b1;
                        rr_addr  = r_cur.set_idx;
                        rr_wdata = !r_rr_q;
                    end
                end
            end
            BK_SWEEP: begin
                meta_we = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (last_cnt) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_out_hit <= n_out_hit;
    end

    // Tag stores: written on a fill, read with registered data.
    always_ff @(posedge i_clk) begin
        if (tag0_we) begin
            r_tag0_mem[r_cur.set_idx] <= r_cur.line;
        end
        if (rd_en) begin
            r_tag0_q <= r_tag0_mem[i_head.set_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag1_we) begin
            r_tag1_mem[r_cur.set_idx] <= r_cur.line;
        end
        if (rd_en) begin
            r_tag1_q <= r_tag1_mem[i_head.set_idx];
        end
    end

    // Valid bits of both ways, cleared by the sweeps.
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_addr] <= meta_wdata;
        end
        if (rd_en) begin
            r_meta_q <= r_meta_mem[i_head.set_idx];
        end
    end

    // Round-robin bits, cleared only by the pass after reset.
    always_ff @(posedge i_clk) begin
        if (rr_we) begin
            r_rr_mem[rr_addr] <= rr_wdata;
        end
        if (rd_en) begin
            r_rr_q <= r_rr_mem[i_head.set_idx];
        end
    end

    assign o_clearing  = (r_state == BK_CLEAR);
    assign o_res_valid = r_out_valid;
    assign o_res_hit   = r_out_hit;

    `CHK_NEXT(a_lookup_result, r_state == BK_LOOKUP, r_out_valid, "lookup gave no result")
    `CHK_NEXT(a_dm_no_way2, (r_state == BK_LOOKUP) && !r_cur.two, r_out_hit != HIT_WAY2,
              "way two hit in direct-mapped mode")
    `CHK_SAME(a_sweep_silent, (r_state == BK_SWEEP) || (r_state == BK_CLEAR), !r_out_valid,
              "result during a sweep")
    `CHK_SAME(a_single_fill, tag0_we || tag1_we, !(tag0_we && tag1_we) && meta_we,
              "fill must write one way and its valid bit")

endmodule

/* rtl/cache_hit_miss_tag_tracker.sv */
// Top level of the cache tag tracker: front, queue and back.
// Depends on chmtt_pkg, chmtt_front, chmtt_queue and chmtt_back.
//
// An item is taken when i_start is high and o_busy is low; the front
// classifies it and queues it (four entries); o_busy is high in reset,
// during the clear pass and when that queue is full. The back takes one
// item at a time: a read inside the cacheable region has a registered tag
// store read, then compare and fill, a read outside it gives its result
// straight from the queue head, and an invalidate is taken from the queue,
// then clears the valid bits of every set, one set per cycle, and gives no
// result. Each read result appears on o_hit_result for exactly one cycle
// with o_hit_valid high, in the order the items were taken, after the queue
// and the result register, and for a read inside the region also the tag
// store read register, later when earlier items still wait in the queue;
// the receiver cannot hold it off. After reset, o_busy stays high while the
// valid and round-robin bits are cleared; configuration writes are taken
// during that time and whenever the block is idle.
module cache_hit_miss_tag_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [chmtt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [chmtt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_operation,
    input  logic [chmtt_pkg::ADDR_W-1:0]    i_read_address,
    output logic                            o_hit_valid,
    output logic [1:0]                      o_hit_result
);
    import chmtt_pkg::*;

    logic      push;
    t_qentry   entry;
    t_qentry   head;
    t_q_status q_status;
    logic      pop;
    logic      clearing;
    t_hit      res_hit;

    // Hold items off in reset, during the clear pass and on a full queue.
    assign o_busy = !i_rst_n || clearing || q_status.full;

    chmtt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_operation    (i_operation),
        .i_read_address (i_read_address),
        .o_push         (push),
        .o_entry        (entry)
    );

    chmtt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    chmtt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_res_valid (o_hit_valid),
        .o_res_hit   (res_hit)
    );

    assign o_hit_result = res_hit;

endmodule
